@@ hw/rtl/tgr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types and constants of the touch gesture recognizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int COORD_BITS = 10;
  localparam int SLOP_BITS  = 8;
  localparam int LONG_BITS  = 16;
  localparam int SWIPE_BITS = 10;
  localparam int TIME_BITS  = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int CMP_BITS = (COORD_BITS > SWIPE_BITS) ? COORD_BITS : SWIPE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_SLOP   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SWIPE_MIN  = 2'd2;

  localparam logic [SLOP_BITS-1:0]  TAP_SLOP_RST   = 8'd12;
  localparam logic [LONG_BITS-1:0]  LONG_PRESS_RST = 16'd600;
  localparam logic [SWIPE_BITS-1:0] SWIPE_MIN_RST  = 10'd40;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DOWN    = 3'd1,
    EV_LONG    = 3'd2,
    EV_TAP     = 3'd3,
    EV_SWIPE_L = 3'd4,
    EV_SWIPE_R = 3'd5
  } event_kind_t;

  typedef struct packed {
    logic                 touching;
    coord_t               pos_x;
    coord_t               pos_y;
    logic [TIME_BITS-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    coord_t      event_x;
    coord_t      event_y;
  } out_item_t;

  typedef struct packed {
    logic [SLOP_BITS-1:0]  tap_slop_px;
    logic [LONG_BITS-1:0]  long_press_ms;
    logic [SWIPE_BITS-1:0] swipe_min_px;
  } cfg_t;

  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    abs_diff = (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/touch_gesture_recognizer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_top
// Tap, long-press and horizontal swipe detector for touch-panel samples.
// ----------------------------------------------------------------------------
// One touch sample in gives exactly one event request out (kind 0 when
// nothing happened). A sample is taken every cycle when the output side keeps
// up; each sample passes through the input register and then the output
// register. The rate is set by the single gesture-state update done in the
// cycle a sample leaves the input register. The user must write thresholds
// through cfg_we/cfg_index/cfg_wdata only while no sample is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_top
  import tgr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output wire logic                     in_stall,
  input  wire in_item_t                 in_item,
  output wire logic                     out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_item,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r, s1_item_nxt;
  logic      out_ready;
  logic      advance;
  logic      in_take;
  out_item_t result;

  assign advance  = s1_valid_r && out_ready;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = in_item;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  tgr_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  tgr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (advance),
    .item   (s1_item_r),
    .result (result)
  );

  tgr_out_reg u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (advance),
    .din   (result),
    .ready (out_ready),
    .stall (out_stall),
    .valid (out_valid),
    .dout  (out_item)
  );

endmodule
`default_nettype wire

@@ hw/rtl/tgr_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_cfg_regs
// Threshold registers written through the plain configuration write port.
// ----------------------------------------------------------------------------
module tgr_cfg_regs
  import tgr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     we,
  input  wire logic [CFG_IDX_BITS-1:0]  index,
  input  wire logic [CFG_DATA_BITS-1:0] wdata,
  output cfg_t                          cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (index)
        CFG_TAP_SLOP:   cfg_nxt.tap_slop_px   = wdata[SLOP_BITS-1:0];
        CFG_LONG_PRESS: cfg_nxt.long_press_ms = wdata[LONG_BITS-1:0];
        CFG_SWIPE_MIN:  cfg_nxt.swipe_min_px  = wdata[SWIPE_BITS-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_slop_px   <= TAP_SLOP_RST;
      cfg_r.long_press_ms <= LONG_PRESS_RST;
      cfg_r.swipe_min_px  <= SWIPE_MIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ hw/rtl/tgr_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_core
// Gesture state and per-sample event decision.
// ----------------------------------------------------------------------------
module tgr_core
  import tgr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      fire,
  input  wire in_item_t  item,
  output out_item_t      result
);

  logic                 finger_down_r, finger_down_nxt;
  logic                 long_done_r, long_done_nxt;
  logic                 has_moved_r, has_moved_nxt;
  coord_t               start_x_r, start_x_nxt;
  coord_t               start_y_r, start_y_nxt;
  coord_t               latest_x_r, latest_x_nxt;
  coord_t               latest_y_r, latest_y_nxt;
  logic [TIME_BITS-1:0] press_time_r, press_time_nxt;

  coord_t               slop;
  coord_t               dx, dy, adx, ady;
  logic [TIME_BITS-1:0] elapsed;
  logic                 moved_now;
  logic                 long_hit;
  logic                 swipe_hit;
  logic                 tap_hit;

  assign slop      = coord_t'(cfg.tap_slop_px);
  assign dx        = abs_diff(item.pos_x, start_x_r);
  assign dy        = abs_diff(item.pos_y, start_y_r);
  assign adx       = abs_diff(latest_x_r, start_x_r);
  assign ady       = abs_diff(latest_y_r, start_y_r);
  assign elapsed   = item.time_ms - press_time_r;
  assign moved_now = has_moved_r || (dx > slop) || (dy > slop);
  assign long_hit  = !long_done_r && !moved_now &&
                     (elapsed >= TIME_BITS'(cfg.long_press_ms));
  assign swipe_hit = !long_done_r &&
                     (CMP_BITS'(adx) >= CMP_BITS'(cfg.swipe_min_px)) && (adx > ady);
  assign tap_hit   = !long_done_r && (adx <= slop) && (ady <= slop);

  // event decision
  always_comb begin
    result = '{event_kind: EV_NONE, event_x: '0, event_y: '0};
    if (item.touching && !finger_down_r) begin
      result = '{event_kind: EV_DOWN, event_x: item.pos_x, event_y: item.pos_y};
    end else if (item.touching) begin
      if (long_hit) begin
        result = '{event_kind: EV_LONG, event_x: start_x_r, event_y: start_y_r};
      end
    end else if (finger_down_r) begin
      if (swipe_hit) begin
        result.event_kind = (latest_x_r < start_x_r) ? EV_SWIPE_L : EV_SWIPE_R;
        result.event_x    = start_x_r;
        result.event_y    = start_y_r;
      end else if (tap_hit) begin
        result = '{event_kind: EV_TAP, event_x: start_x_r, event_y: start_y_r};
      end
    end
  end

  // state update
  always_comb begin
    finger_down_nxt = finger_down_r;
    long_done_nxt   = long_done_r;
    has_moved_nxt   = has_moved_r;
    start_x_nxt     = start_x_r;
    start_y_nxt     = start_y_r;
    latest_x_nxt    = latest_x_r;
    latest_y_nxt    = latest_y_r;
    press_time_nxt  = press_time_r;
    if (fire) begin
      if (item.touching && !finger_down_r) begin
        finger_down_nxt = 1'b1;
        long_done_nxt   = 1'b0;
        has_moved_nxt   = 1'b0;
        start_x_nxt     = item.pos_x;
        start_y_nxt     = item.pos_y;
        latest_x_nxt    = item.pos_x;
        latest_y_nxt    = item.pos_y;
        press_time_nxt  = item.time_ms;
      end else if (item.touching) begin
        latest_x_nxt  = item.pos_x;
        latest_y_nxt  = item.pos_y;
        has_moved_nxt = moved_now;
        if (long_hit) begin
          long_done_nxt = 1'b1;
        end
      end else begin
        finger_down_nxt = 1'b0;
        long_done_nxt   = 1'b0;
        has_moved_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finger_down_r <= 1'b0;
      long_done_r   <= 1'b0;
      has_moved_r   <= 1'b0;
    end else begin
      finger_down_r <= finger_down_nxt;
      long_done_r   <= long_done_nxt;
      has_moved_r   <= has_moved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_x_r    <= start_x_nxt;
    start_y_r    <= start_y_nxt;
    latest_x_r   <= latest_x_nxt;
    latest_y_r   <= latest_y_nxt;
    press_time_r <= press_time_nxt;
  end

  a_long_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.event_kind == EV_LONG) |=> (long_done_r && finger_down_r))
    else $error("long press did not mark long_done");

  a_down_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.event_kind == EV_DOWN) |=>
      (finger_down_r && !long_done_r && !has_moved_r))
    else $error("down request did not arm gesture state");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !item.touching) |=> (!finger_down_r && !long_done_r && !has_moved_r))
    else $error("release did not clear gesture state");

  a_done_needs_down: assert property (@(posedge clk) disable iff (!rst_n)
    long_done_r |-> finger_down_r)
    else $error("long_done set while finger up");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!finger_down_r && !long_done_r && !has_moved_r))
    else $error("reset did not clear gesture state");

endmodule
`default_nettype wire

@@ hw/rtl/tgr_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgr_out_reg
// Result register that holds an event request until the sink takes it.
// ----------------------------------------------------------------------------
module tgr_out_reg
  import tgr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire out_item_t din,
  output wire logic      ready,
  input  wire logic      stall,
  output wire logic      valid,
  output out_item_t      dout
);

  logic      valid_r, valid_nxt;
  out_item_t item_r, item_nxt;

  assign ready = !valid_r || !stall;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = 1'b1;
      item_nxt  = din;
    end else if (ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign valid = valid_r;
  assign dout  = item_r;

endmodule
`default_nettype wire

@@ tb/touch_gesture_recognizer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_checker
// Watches the sample, event and register ports of the gesture recognizer,
// predicts the event for each accepted sample from its own copy of the
// gesture state and thresholds, and compares every accepted event field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_checker
  import tgr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  in_item_t                 in_item,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  out_item_t                out_item,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output int                       mismatch_count,
  output int                       events_pending
);

  logic [SLOP_BITS-1:0]  slop_px;
  logic [LONG_BITS-1:0]  hold_ms;
  logic [SWIPE_BITS-1:0] swipe_px;

  logic                 held;
  logic                 long_fired;
  logic                 moved;
  coord_t               origin_x;
  coord_t               origin_y;
  coord_t               last_x;
  coord_t               last_y;
  logic [TIME_BITS-1:0] press_ms;

  out_item_t expected_events[$];

  function automatic int coord_gap(input coord_t a, input coord_t b);
    if (a > b) begin
      return int'(a) - int'(b);
    end
    return int'(b) - int'(a);
  endfunction

  // advances the gesture state by one sample and gives the event it raises
  function automatic out_item_t gesture_event(input in_item_t s);
    out_item_t            ev;
    logic [TIME_BITS-1:0] elapsed;
    logic                 was_long;
    int                   dx;
    int                   dy;
    ev.event_kind = EV_NONE;
    ev.event_x    = '0;
    ev.event_y    = '0;
    if (s.touching && !held) begin
      held       = 1'b1;
      long_fired = 1'b0;
      moved      = 1'b0;
      origin_x   = s.pos_x;
      origin_y   = s.pos_y;
      last_x     = s.pos_x;
      last_y     = s.pos_y;
      press_ms   = s.time_ms;
      ev.event_kind = EV_DOWN;
      ev.event_x    = s.pos_x;
      ev.event_y    = s.pos_y;
    end else if (s.touching) begin
      last_x = s.pos_x;
      last_y = s.pos_y;
      if (coord_gap(s.pos_x, origin_x) > slop_px || coord_gap(s.pos_y, origin_y) > slop_px) begin
        moved = 1'b1;
      end
      elapsed = s.time_ms - press_ms;
      if (!long_fired && !moved && elapsed >= TIME_BITS'(hold_ms)) begin
        long_fired    = 1'b1;
        ev.event_kind = EV_LONG;
        ev.event_x    = origin_x;
        ev.event_y    = origin_y;
      end
    end else if (held) begin
      was_long   = long_fired;
      dx         = coord_gap(last_x, origin_x);
      dy         = coord_gap(last_y, origin_y);
      held       = 1'b0;
      long_fired = 1'b0;
      moved      = 1'b0;
      if (!was_long) begin
        if (dx >= swipe_px && dx > dy) begin
          ev.event_kind = (last_x < origin_x) ? EV_SWIPE_L : EV_SWIPE_R;
          ev.event_x    = origin_x;
          ev.event_y    = origin_y;
        end else if (dx <= slop_px && dy <= slop_px) begin
          ev.event_kind = EV_TAP;
          ev.event_x    = origin_x;
          ev.event_y    = origin_y;
        end
      end
    end
    return ev;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      mismatch_count = 0;
      slop_px    = TAP_SLOP_RST;
      hold_ms    = LONG_PRESS_RST;
      swipe_px   = SWIPE_MIN_RST;
      held       = 1'b0;
      long_fired = 1'b0;
      moved      = 1'b0;
      origin_x   = '0;
      origin_y   = '0;
      last_x     = '0;
      last_y     = '0;
      press_ms   = '0;
      expected_events.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          flag_mismatch($sformatf("event kind %0d with no sample waiting",
                                  out_item.event_kind));
        end else begin
          want = expected_events.pop_front();
          if (out_item.event_kind !== want.event_kind) begin
            flag_mismatch($sformatf("event_kind expected %0d got %0d",
                                    want.event_kind, out_item.event_kind));
          end
          if (out_item.event_x !== want.event_x) begin
            flag_mismatch($sformatf("event_x expected %0d got %0d",
                                    want.event_x, out_item.event_x));
          end
          if (out_item.event_y !== want.event_y) begin
            flag_mismatch($sformatf("event_y expected %0d got %0d",
                                    want.event_y, out_item.event_y));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TAP_SLOP:   slop_px  = cfg_wdata[SLOP_BITS-1:0];
          CFG_LONG_PRESS: hold_ms  = cfg_wdata[LONG_BITS-1:0];
          CFG_SWIPE_MIN:  swipe_px = cfg_wdata[SWIPE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_events.push_back(gesture_event(in_item));
      end
    end
    events_pending = expected_events.size();
  end

endmodule

@@ tb/tb_touch_gesture_recognizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_gesture_recognizer_top
// Drives touch samples and threshold writes into the gesture recognizer:
// directed landings, taps, long presses, swipes and dead releases first, then
// random gestures under several threshold settings, with random idling on both
// sides in most phases. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_touch_gesture_recognizer_top;
  import tgr_pkg::*;

  localparam int COORD_MAX = 2**COORD_BITS - 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {
    G_TAP,
    G_HOLD,
    G_SWIPE,
    G_DRAG,
    G_WANDER,
    G_NOISE
  } gesture_style_t;

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_item_t                 in_item   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_item;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  int                       mismatch_count;
  int                       events_pending;

  int                   sender_idle_pct   = 17;
  int                   receiver_idle_pct = 50;
  int                   hold_off_cycles   = 0;
  int                   slop_now          = TAP_SLOP_RST;
  int                   hold_now          = LONG_PRESS_RST;
  int                   swipe_now         = SWIPE_MIN_RST;
  logic [TIME_BITS-1:0] stamp_ms          = '0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  touch_gesture_recognizer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  touch_gesture_recognizer_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .events_pending (events_pending)
  );

  // event receiver: long hold-offs first, random stalls otherwise
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  function automatic in_item_t make_sample(input logic touch, input int x, input int y,
                                           input logic [TIME_BITS-1:0] t);
    in_item_t s;
    if (x < 0) x = 0;
    if (x > COORD_MAX) x = COORD_MAX;
    if (y < 0) y = 0;
    if (y > COORD_MAX) y = COORD_MAX;
    s.touching = touch;
    s.pos_x    = coord_t'(x);
    s.pos_y    = coord_t'(y);
    s.time_ms  = t;
    return s;
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(7) == 0) begin
      return $urandom_range(1) ? COORD_MAX : 0;
    end
    return $urandom_range(COORD_MAX);
  endfunction

  function automatic int wobble(input int c, input int r);
    return c + int'($urandom_range(0, 2 * r + 2)) - (r + 1);
  endfunction

  task automatic push_sample(input in_item_t s);
    int gap;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_events();
    @(negedge clk);
    in_valid <= 1'b0;
    while (events_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_TAP_SLOP:   slop_now  = data[SLOP_BITS-1:0];
      CFG_LONG_PRESS: hold_now  = data[LONG_BITS-1:0];
      CFG_SWIPE_MIN:  swipe_now = data[SWIPE_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input int slop, input int hold, input int swipe);
    drain_events();
    write_reg(CFG_TAP_SLOP, {8'($urandom), 8'(slop)});
    write_reg(CFG_LONG_PRESS, 16'(hold));
    write_reg(CFG_SWIPE_MIN, {6'($urandom), 10'(swipe)});
    write_reg(CFG_UNUSED, 16'($urandom));
  endtask

  task automatic play_gesture();
    gesture_style_t style;
    int             n;
    int             ox;
    int             oy;
    int             x;
    int             y;
    int             dir;
    style = gesture_style_t'($urandom_range(0, 5));
    if (style == G_NOISE) begin
      repeat ($urandom_range(1, 3)) begin
        push_sample(make_sample($urandom_range(1), pick_coord(), pick_coord(), $urandom));
      end
      return;
    end
    if ($urandom_range(3) == 0) stamp_ms = $urandom;
    ox  = pick_coord();
    oy  = pick_coord();
    x   = ox;
    y   = oy;
    dir = $urandom_range(1) ? 1 : -1;
    push_sample(make_sample(1'b1, ox, oy, stamp_ms));
    n = $urandom_range(0, 6);
    repeat (n) begin
      case (style)
        G_TAP, G_HOLD: begin
          x = wobble(ox, slop_now);
          y = wobble(oy, slop_now);
        end
        G_SWIPE: begin
          x = x + dir * int'($urandom_range(0, swipe_now / 2 + 8));
          y = wobble(oy, slop_now);
        end
        G_DRAG: begin
          x = wobble(ox, slop_now);
          y = y + dir * int'($urandom_range(0, swipe_now / 2 + 8));
        end
        default: begin
          x = pick_coord();
          y = pick_coord();
        end
      endcase
      if (style == G_HOLD) begin
        stamp_ms = stamp_ms + $urandom_range(0, hold_now / 2 + 1);
      end else begin
        stamp_ms = stamp_ms + $urandom_range(0, 50);
      end
      push_sample(make_sample(1'b1, x, y, stamp_ms));
    end
    stamp_ms = stamp_ms + $urandom_range(0, 50);
    push_sample(make_sample(1'b0, pick_coord(), pick_coord(), stamp_ms));
  endtask

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // no finger while up
    push_sample(make_sample(1'b0, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF));
    // long press across the time wrap, then held and released after it fired
    push_sample(make_sample(1'b1, 0, 0, 32'hFFFF_FF00));
    push_sample(make_sample(1'b1, 5, 3, 32'h0000_0100));
    push_sample(make_sample(1'b1, 3, 3, 32'h0000_0160));
    push_sample(make_sample(1'b1, 2, 2, 32'h0000_0400));
    push_sample(make_sample(1'b0, 700, 700, 32'h0000_0410));
    // tap at the slop limit
    push_sample(make_sample(1'b1, COORD_MAX, COORD_MAX, 32'd1000));
    push_sample(make_sample(1'b1, COORD_MAX - 12, COORD_MAX, 32'd1100));
    push_sample(make_sample(1'b0, 0, 0, 32'd1150));
    // swipe right at the minimum travel
    push_sample(make_sample(1'b1, 100, 500, 32'd2000));
    push_sample(make_sample(1'b1, 140, 510, 32'd2050));
    push_sample(make_sample(1'b0, 900, 10, 32'd2060));
    // swipe left from the far corner
    push_sample(make_sample(1'b1, COORD_MAX, 0, 32'd3000));
    push_sample(make_sample(1'b1, COORD_MAX - 40, 0, 32'd3020));
    push_sample(make_sample(1'b0, 0, COORD_MAX, 32'd3030));
    // diagonal release meets neither rule
    push_sample(make_sample(1'b1, 500, 500, 32'd4000));
    push_sample(make_sample(1'b1, 540, 540, 32'd4010));
    push_sample(make_sample(1'b0, 500, 500, 32'd4020));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: apply_settings(0, 0, 0);
        2: apply_settings(255, 65535, 1023);
        3: apply_settings($urandom_range(255), $urandom_range(65535), $urandom_range(1023));
        4: apply_settings(TAP_SLOP_RST, LONG_PRESS_RST, SWIPE_MIN_RST);
        5: apply_settings($urandom_range(30), $urandom_range(200), $urandom_range(100));
        default: ;
      endcase
      if (phase < 2) begin
        sender_idle_pct   = 17;
        receiver_idle_pct = 50;
      end else if (phase < 4) begin
        sender_idle_pct   = 50;
        receiver_idle_pct = 17;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      for (int g = 0; g < 30; g++) begin
        if (g == 10 && (phase == 1 || phase == 4)) hold_off_cycles = 150;
        if (g == 10 && phase == 3) drain_events();
        play_gesture();
      end
    end

    drain_events();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && events_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
